/* design/ssp_rx_pkg.sv */
// ----------------------------------------------------------------------------
// Servo status packet receiver package
// Shared word types, command and status codes, and receiver phases.
// ----------------------------------------------------------------------------
package ssp_rx_pkg;

  // Command codes carried by an input word
  localparam logic [1:0] CmdByte = 2'd0;
  localparam logic [1:0] CmdTick = 2'd1;
  localparam logic [1:0] CmdArm  = 2'd2;

  // Status codes carried by a result word
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StTimeout = 2'd1;
  localparam logic [1:0] StMalform = 2'd2;
  localparam logic [1:0] StBadSum  = 2'd3;

  // Frame constants
  localparam logic [7:0] HdrByte = 8'hFF;
  localparam logic [7:0] FailErr = 8'h80;

  // Register map
  localparam logic [1:0] RegTimeoutAddr = 2'd0;
  localparam logic [15:0] TimeoutReset  = 16'd100;

  typedef enum logic [2:0] {
    PhIdle = 3'd0,
    PhHdr1 = 3'd1,
    PhHdr2 = 3'd2,
    PhId   = 3'd3,
    PhLen  = 3'd4,
    PhErr  = 3'd5,
    PhPar  = 3'd6,
    PhSum  = 3'd7
  } phase_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  servo_id;
    logic [7:0]  error_byte;
    logic [7:0]  param_count;
    logic [15:0] read_value;
  } out_word_t;

endpackage

/* design/servo_status_packet_receiver_core.sv */
// ----------------------------------------------------------------------------
// Servo status packet receiver core
// Parses one status reply frame per arm command and reports ok, timeout,
// malformed frame or checksum mismatch with id, error, count and value.
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  ---------+-----------+------------------------------------------------
//  in       | sink      | in_valid_i, in_ready_o, in_word_i
//  out      | source    | out_valid_o, out_ready_i, out_word_o
//  cfg      | APB slave | psel_i, penable_i, pwrite_i, paddr_i, pwdata_i,
//           |           | prdata_o, pready_o
//
//  One word is taken per cycle while in_ready_o is high; its result goes
//  to the output register, or to the skid register if that is full. The
//  skid keeps in_ready_o high while one result waits; it drops only when
//  both hold words. Reset brings the receiver to idle, not armed, with
//  timeout_ticks at 100. Configuration writes take effect the next cycle.
// ----------------------------------------------------------------------------
module servo_status_packet_receiver_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ssp_rx_pkg::in_word_t  in_word_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ssp_rx_pkg::out_word_t out_word_o,
  // configuration
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [1:0]            paddr_i,
  input  logic [31:0]           pwdata_i,
  output logic [31:0]           prdata_o,
  output logic                  pready_o
);
  import ssp_rx_pkg::*;

  // configuration
  logic [15:0] timeout_q;
  logic        cfg_wr;

  // frame state
  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  got_id_q, got_id_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  got_err_q, got_err_d;
  logic [7:0]  params_q, params_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] value_q, value_d;

  // handshake and result path
  logic        accept;
  logic        pop;
  logic        res_valid;
  out_word_t   res_word;
  logic        out_valid_q;
  out_word_t   out_q;
  logic        skid_valid_q;
  out_word_t   skid_q;

  // helpers
  logic [15:0] tick_inc;
  logic [7:0]  params_inc;
  logic [7:0]  sum_add;
  logic        live;

  // APB register access
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i == RegTimeoutAddr);
  assign prdata_o = (paddr_i == RegTimeoutAddr) ? {16'd0, timeout_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_wr) begin
      timeout_q <= pwdata_i[15:0];
    end
  end

  // Handshake
  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  // Shared arithmetic
  assign tick_inc   = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  assign params_inc = params_q + 8'd1;
  assign sum_add    = sum_q + in_word_i.rx_byte;
  assign live       = accept && (phase_q != PhIdle) &&
                      (in_word_i.cmd == CmdByte || in_word_i.cmd == CmdTick);

  // Result decision for the accepted word
  always_comb begin
    res_valid            = 1'b0;
    res_word.status      = StTimeout;
    res_word.servo_id    = got_id_q;
    res_word.error_byte  = FailErr;
    res_word.param_count = params_q;
    res_word.read_value  = value_q;
    if (live) begin
      if (in_word_i.cmd == CmdTick) begin
        res_valid = (tick_inc >= timeout_q);
      end else begin
        unique case (phase_q)
          PhHdr1, PhHdr2: begin
            res_valid       = (in_word_i.rx_byte != HdrByte);
            res_word.status = StMalform;
          end
          PhLen: begin
            res_valid       = (in_word_i.rx_byte < 8'd2);
            res_word.status = StMalform;
          end
          PhSum: begin
            res_valid           = 1'b1;
            res_word.status     = (in_word_i.rx_byte == ~sum_q) ? StOk : StBadSum;
            res_word.error_byte = got_err_q;
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end
  end

  // Next phase and frame fields
  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    got_id_d  = got_id_q;
    len_d     = len_q;
    got_err_d = got_err_q;
    params_d  = params_q;
    sum_d     = sum_q;
    value_d   = value_q;
    if (accept && in_word_i.cmd == CmdArm) begin
      // restart the wait, drop any partial frame
      phase_d   = PhHdr1;
      tick_d    = 16'd0;
      got_id_d  = 8'd0;
      len_d     = 8'd0;
      got_err_d = 8'd0;
      params_d  = 8'd0;
      sum_d     = 8'd0;
      value_d   = 16'd0;
    end else if (live && in_word_i.cmd == CmdTick) begin
      tick_d = tick_inc;
    end else if (live) begin
      unique case (phase_q)
        PhHdr1: phase_d = PhHdr2;
        PhHdr2: phase_d = PhId;
        PhId: begin
          got_id_d = in_word_i.rx_byte;
          sum_d    = in_word_i.rx_byte;
          phase_d  = PhLen;
        end
        PhLen: begin
          len_d   = in_word_i.rx_byte;
          sum_d   = sum_add;
          phase_d = PhErr;
        end
        PhErr: begin
          got_err_d = in_word_i.rx_byte;
          sum_d     = sum_add;
          tick_d    = 16'd0;
          phase_d   = (len_q == 8'd2) ? PhSum : PhPar;
        end
        PhPar: begin
          sum_d = sum_add;
          if (params_q == 8'd0) begin
            value_d = {8'd0, in_word_i.rx_byte};
          end else if (params_q == 8'd1) begin
            value_d = {in_word_i.rx_byte, value_q[7:0]};
          end
          params_d = params_inc;
          if (({1'b0, params_inc} + 9'd2) >= {1'b0, len_q}) begin
            phase_d = PhSum;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
    // a result closes the wait
    if (res_valid) begin
      phase_d = PhIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      tick_q    <= 16'd0;
      got_id_q  <= 8'd0;
      len_q     <= 8'd0;
      got_err_q <= 8'd0;
      params_q  <= 8'd0;
      sum_q     <= 8'd0;
      value_q   <= 16'd0;
    end else begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      got_id_q  <= got_id_d;
      len_q     <= len_d;
      got_err_q <= got_err_d;
      params_q  <= params_d;
      sum_q     <= sum_d;
      value_q   <= value_d;
    end
  end

  // Output register and skid: valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid && out_valid_q && !pop) begin
      skid_valid_q <= 1'b1;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register and skid: payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (res_valid && out_valid_q && !pop) begin
      skid_q <= res_word;
    end else if (res_valid) begin
      out_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  // A waiting skid word implies a word on the output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without output word");

  // No result while not armed
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle && in_word_i.cmd != CmdArm) |-> !res_valid)
    else $error("result produced while idle");

  // A result ends the wait
  a_result_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> (phase_q == PhIdle))
    else $error("wait not closed after result");

  // A result is never dropped: it lands in the output or skid register
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q)
    else $error("result lost");
`endif

endmodule

/* tb/sv/tb_servo_status_packet_receiver_core.sv */
// ----------------------------------------------------------------------------
// Servo status packet receiver core testbench
// Feeds arm, tick and byte words through the input channel and keeps its own
// parser of the reply frame. Every result word is checked field by field
// against the oldest predicted status. Configuration changes between phases
// over the APB port, and both channels idle at random in the middle phases.
// ----------------------------------------------------------------------------
module tb_servo_status_packet_receiver_core;
  import ssp_rx_pkg::*;

  // Spare command code, ignored by the receiver
  localparam logic [1:0] CmdSpare     = 2'd3;
  localparam int         SettleCycles = 6;
  localparam int         RunLimit     = 4000000;

  logic        clk_i      = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready_o;
  in_word_t    in_word    = '0;
  logic        out_valid_o;
  logic        out_ready  = 1'b0;
  out_word_t   out_word_o;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [1:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  servo_status_packet_receiver_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata_o),
    .pready_o    (pready_o)
  );

  // Clock: period of two time units
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  in_word_t  bus_word_q[$];
  out_word_t status_q[$];
  int        stim_count = 0;
  int        mismatches = 0;
  bit        word_taken = 1'b0;
  bit        sender_idling = 1'b0;
  bit        receiver_idling = 1'b0;
  int        send_gap = 0;
  int        hold_gap = 0;

  // Parser state mirrored from the block
  logic [15:0] timeout_cfg = TimeoutReset;
  phase_e      rx_phase    = PhIdle;
  logic [15:0] tick_cnt    = '0;
  logic [7:0]  frame_id    = '0;
  logic [7:0]  frame_len   = '0;
  logic [7:0]  frame_err   = '0;
  logic [7:0]  param_cnt   = '0;
  logic [7:0]  byte_sum    = '0;
  logic [15:0] first_params = '0;

  // Advance the parser by one accepted word; queue the status it closes with
  function automatic void predict_status(in_word_t w);
    bit         done;
    logic [1:0] st;
    logic [7:0] eb;
    done = 1'b0;
    st   = StOk;
    eb   = FailErr;
    if (w.cmd == CmdArm) begin
      rx_phase     = PhHdr1;
      tick_cnt     = '0;
      frame_id     = '0;
      frame_len    = '0;
      frame_err    = '0;
      param_cnt    = '0;
      byte_sum     = '0;
      first_params = '0;
    end else if (w.cmd == CmdTick && rx_phase != PhIdle) begin
      if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= timeout_cfg) begin
        done = 1'b1;
        st   = StTimeout;
      end
    end else if (w.cmd == CmdByte && rx_phase != PhIdle) begin
      case (rx_phase)
        PhHdr1: begin
          if (w.rx_byte != HdrByte) begin
            done = 1'b1;
            st   = StMalform;
          end else rx_phase = PhHdr2;
        end
        PhHdr2: begin
          if (w.rx_byte != HdrByte) begin
            done = 1'b1;
            st   = StMalform;
          end else rx_phase = PhId;
        end
        PhId: begin
          frame_id = w.rx_byte;
          byte_sum = w.rx_byte;
          rx_phase = PhLen;
        end
        PhLen: begin
          frame_len = w.rx_byte;
          if (w.rx_byte < 8'd2) begin
            done = 1'b1;
            st   = StMalform;
          end else begin
            byte_sum = byte_sum + w.rx_byte;
            rx_phase = PhErr;
          end
        end
        PhErr: begin
          frame_err = w.rx_byte;
          byte_sum  = byte_sum + w.rx_byte;
          tick_cnt  = '0;
          rx_phase  = (frame_len == 8'd2) ? PhSum : PhPar;
        end
        PhPar: begin
          byte_sum = byte_sum + w.rx_byte;
          if (param_cnt == 8'd0) first_params = {8'h00, w.rx_byte};
          else if (param_cnt == 8'd1) first_params[15:8] = w.rx_byte;
          param_cnt = param_cnt + 8'd1;
          if (int'(param_cnt) + 2 >= int'(frame_len)) rx_phase = PhSum;
        end
        default: begin
          done = 1'b1;
          eb   = frame_err;
          st   = (w.rx_byte == ~byte_sum) ? StOk : StBadSum;
        end
      endcase
    end
    if (done) begin
      status_q.push_back('{status: st, servo_id: frame_id, error_byte: eb,
                           param_count: param_cnt, read_value: first_params});
      rx_phase = PhIdle;
    end
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Take the word at the accepting edge
  always @(posedge clk_i) begin
    if (rst_n && in_valid && in_ready_o) begin
      predict_status(in_word);
      word_taken = 1'b1;
    end
  end

  // Drive the input channel: hold until taken, then idle or present the next
  always @(negedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      // hold the word
    end else begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (bus_word_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (sender_idling && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_word  <= bus_word_q.pop_front();
      end
    end
  end

  // Stall the result channel in short bursts
  always @(negedge clk_i) begin
    if (hold_gap > 0) begin
      hold_gap--;
      out_ready <= 1'b0;
    end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
      hold_gap = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result word against the oldest predicted status
  always @(posedge clk_i) begin
    out_word_t exp_word;
    if (rst_n && out_valid_o && out_ready) begin
      if (status_q.size() == 0) begin
        $error("result word with no status pending: 0x%0h", out_word_o);
        mismatches++;
      end else begin
        exp_word = status_q.pop_front();
        check_field("status", exp_word.status, out_word_o.status);
        check_field("servo_id", exp_word.servo_id, out_word_o.servo_id);
        check_field("error_byte", exp_word.error_byte, out_word_o.error_byte);
        check_field("param_count", exp_word.param_count, out_word_o.param_count);
        check_field("read_value", exp_word.read_value, out_word_o.read_value);
      end
    end
  end

  task automatic push_word(logic [1:0] cmd, logic [7:0] b, bit counted);
    in_word_t w;
    w.cmd     = cmd;
    w.rx_byte = b;
    bus_word_q.push_back(w);
    if (counted) stim_count++;
  endtask

  // Push a frame byte, sometimes followed by a tick or two
  task automatic push_frame_byte(logic [7:0] b, int tick_odds);
    push_word(CmdByte, b, 1'b1);
    if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1)
      repeat ($urandom_range(1, 2)) push_word(CmdTick, 8'($urandom), 1'b1);
  endtask

  // Arm, then send one whole reply frame
  task automatic queue_frame(logic [7:0] id, logic [7:0] len, logic [7:0] err,
                             bit bad_sum, int tick_odds);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] ck;
    push_word(CmdArm, 8'($urandom), 1'b1);
    push_frame_byte(HdrByte, tick_odds);
    push_frame_byte(HdrByte, tick_odds);
    push_frame_byte(id, tick_odds);
    push_frame_byte(len, tick_odds);
    push_frame_byte(err, tick_odds);
    sum = id + len + err;
    for (int i = 0; i < int'(len) - 2; i++) begin
      if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else b = 8'($urandom);
      sum = sum + b;
      push_frame_byte(b, tick_odds);
    end
    ck = ~sum;
    if (bad_sum) ck = ck ^ 8'($urandom_range(1, 255));
    push_word(CmdByte, ck, 1'b1);
  endtask

  // Mostly short frames, now and then a long one
  function automatic logic [7:0] pick_len();
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(2, 255));
    return 8'($urandom_range(2, 8));
  endfunction

  task automatic run_random(int n_items);
    int goal;
    int kind;
    int ticks;
    goal = stim_count + n_items;
    while (stim_count < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        queue_frame(8'($urandom), pick_len(), 8'($urandom), 1'b0, 12);
      end else if (kind < 70) begin
        queue_frame(8'($urandom), pick_len(), 8'($urandom), 1'b1, 12);
      end else if (kind < 75) begin
        // broken header in either position
        push_word(CmdArm, 8'($urandom), 1'b1);
        if ($urandom_range(0, 1)) push_word(CmdByte, HdrByte, 1'b1);
        push_word(CmdByte, 8'($urandom_range(0, 254)), 1'b1);
      end else if (kind < 80) begin
        // length too short
        push_word(CmdArm, 8'($urandom), 1'b1);
        push_word(CmdByte, HdrByte, 1'b1);
        push_word(CmdByte, HdrByte, 1'b1);
        push_word(CmdByte, 8'($urandom), 1'b1);
        push_word(CmdByte, 8'($urandom_range(0, 1)), 1'b1);
      end else if (kind < 85) begin
        // partial frame dropped by a fresh arm
        push_word(CmdArm, 8'($urandom), 1'b1);
        push_word(CmdByte, HdrByte, 1'b1);
        push_word(CmdByte, HdrByte, 1'b1);
        repeat ($urandom_range(0, 4)) push_frame_byte(8'($urandom), 6);
        queue_frame(8'($urandom), pick_len(), 8'($urandom), 1'b0, 0);
      end else if (kind < 90) begin
        // run the wait out, or only tick it when the timeout is long
        push_word(CmdArm, 8'($urandom), 1'b1);
        if (timeout_cfg > 16'd400) ticks = $urandom_range(1, 40);
        else ticks = (timeout_cfg == 16'd0 ? 1 : int'(timeout_cfg)) + $urandom_range(0, 1);
        repeat (ticks) push_word(CmdTick, 8'($urandom), 1'b1);
      end else if (kind < 95) begin
        // noise, including the spare command
        repeat ($urandom_range(1, 6))
          push_word(2'($urandom_range(0, 3)), 8'($urandom), 1'b0);
      end else begin
        queue_frame(8'($urandom), pick_len(), 8'($urandom), 1'b0, 2);
      end
    end
  endtask

  // Wait for the input queue and every pending status to drain
  task automatic wait_for_replies();
    do @(posedge clk_i);
    while (!(bus_word_q.size() == 0 && !in_valid && status_q.size() == 0));
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_timeout_reg();
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= RegTimeoutAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready_o);
    check_field("timeout_ticks", timeout_cfg, prdata_o[15:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timeout(logic [15:0] ticks);
    logic [15:0] upper;
    upper = 16'($urandom);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= RegTimeoutAddr;
    pwdata  <= {upper, ticks};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready_o);
    timeout_cfg = ticks;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_timeout_reg();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    check_timeout_reg();

    // Directed: ignored words, good frame, broken header, short length,
    // re-arm mid-frame and a checksum mismatch
    push_word(CmdByte, 8'hAA, 1'b1);
    push_word(CmdTick, 8'h55, 1'b1);
    push_word(CmdSpare, 8'hFF, 1'b1);
    queue_frame(8'h00, 8'h02, 8'h00, 1'b0, 0);
    push_word(CmdArm, 8'h00, 1'b1);
    push_word(CmdByte, 8'h00, 1'b1);
    push_word(CmdArm, 8'h00, 1'b1);
    push_word(CmdByte, HdrByte, 1'b1);
    push_word(CmdByte, 8'h7F, 1'b1);
    push_word(CmdArm, 8'h00, 1'b1);
    push_word(CmdByte, HdrByte, 1'b1);
    push_word(CmdByte, HdrByte, 1'b1);
    push_word(CmdByte, 8'h07, 1'b1);
    push_word(CmdByte, 8'h01, 1'b1);
    push_word(CmdArm, 8'h00, 1'b1);
    push_word(CmdByte, HdrByte, 1'b1);
    push_word(CmdSpare, 8'h12, 1'b1);
    queue_frame(8'hFF, 8'h04, 8'hFF, 1'b1, 0);
    wait_for_replies();

    // Zero timeout: the first tick of a wait ends it
    set_timeout(16'd0);
    push_word(CmdArm, 8'h00, 1'b1);
    push_word(CmdTick, 8'h00, 1'b1);
    wait_for_replies();

    sender_idling   = 1'b1;
    receiver_idling = 1'b1;
    set_timeout(16'd1);
    run_random(150);
    wait_for_replies();

    // Longest timeout: a burst of ticks leaves the wait open
    set_timeout(16'hFFFF);
    push_word(CmdArm, 8'h00, 1'b1);
    repeat (20) push_word(CmdTick, 8'($urandom), 1'b1);
    run_random(150);
    wait_for_replies();

    repeat (5) begin
      set_timeout(16'($urandom_range(2, 300)));
      run_random(180);
      wait_for_replies();
    end

    // Last stretch at full rate
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    set_timeout(16'($urandom_range(20, 200)));
    run_random(200);
    wait_for_replies();

    if (mismatches == 0 && status_q.size() == 0) begin
      $display("tb_servo_status_packet_receiver_core: PASS");
    end else begin
      $display("tb_servo_status_packet_receiver_core: FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(RunLimit);
    $display("tb_servo_status_packet_receiver_core: FAIL");
    $finish;
  end

endmodule
